### rtl/char_lcd_write_sequencer_top_macros.svh
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_top_macros.svh
// Assertion macros shared by the checker of the character LCD write sequencer
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CLWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CLWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/clws_pkg.sv
// ---------------------------------------------------------------------------
// clws_pkg
// Types and constants of the character LCD write sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package clws_pkg;

    // request kinds as carried in the mode field
    typedef enum logic [1:0] {
        REQ_CHAR   = 2'd0,
        REQ_GOTO   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NUMBER = 2'd3
    } req_kind_t;

    // kinds of bus byte the datapath can put out
    typedef enum logic [1:0] {
        EMIT_DATA,
        EMIT_GOTO,
        EMIT_WRAP,
        EMIT_CLEAR
    } emit_kind_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GOTO,
        ST_CLEAR,
        ST_DIV_MUL,
        ST_DIV_STORE,
        ST_SIGN,
        ST_DIGIT,
        ST_CHAR
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       div_mul;
        logic       div_store;
        logic       pick_sign;
        logic       pick_digit;
        logic       emit;
        emit_kind_t kind;
        logic       last;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic emit_done;
        logic need_wrap;
        logic div_done;
        logic negative;
        logic char_final;
    } dp_status_t;

    localparam logic [7:0]  CMD_CLEAR        = 8'h01;
    localparam logic [7:0]  CMD_SET_ADDR     = 8'h80;
    localparam logic [6:0]  SECOND_LINE_BASE = 7'h40;
    localparam logic [7:0]  LOW_NIBBLE       = 8'h0F;
    localparam logic [7:0]  CHAR_MINUS       = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO        = 8'h30;

    // divide by ten: q = (x * RECIP_10) >> RECIP_SHIFT, exact for 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;
    localparam int          DIGIT_W     = 4;

    // set-address command byte for a row and column
    function automatic logic [7:0] set_addr_byte(input logic row, input logic [5:0] col);
        logic [6:0] addr;
        begin
            addr = row ? (SECOND_LINE_BASE + {1'b0, col}) : {1'b0, col};
            return CMD_SET_ADDR | {1'b0, addr};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/clws_if.sv
// ---------------------------------------------------------------------------
// clws_if
// Request, display bus and configuration channels with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

// request channel
interface clws_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [7:0]         char_code;
    logic               row;
    logic [5:0]         column;
    logic signed [31:0] number;

    modport source (output valid, mode, char_code, row, column, number, input ready);
    modport sink   (input valid, mode, char_code, row, column, number, output ready);
endinterface

// display bus channel
interface clws_bus_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, register_select, bus_byte, last, input ready);
    modport sink   (input valid, register_select, bus_byte, last, output ready);
endinterface

// configuration write channel
interface clws_cfg_if;
    logic valid;
    logic ready;
    logic interface_mode;

    modport source (output valid, interface_mode, input ready);
    modport sink   (input valid, interface_mode, output ready);
endinterface

`default_nettype wire

### rtl/clws_ctrl.sv
// ---------------------------------------------------------------------------
// clws_ctrl
// Controller: walks each request through conversion and byte emission
// ---------------------------------------------------------------------------
`default_nettype none

module clws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  clws_pkg::req_kind_t    req_mode,
    output logic                   req_ready,
    output clws_pkg::dp_cmd_t      cmd,
    input  clws_pkg::dp_status_t   status
);
    import clws_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_mode)
                        REQ_CHAR:   state_next = ST_CHAR;
                        REQ_GOTO:   state_next = ST_GOTO;
                        REQ_CLEAR:  state_next = ST_CLEAR;
                        REQ_NUMBER: state_next = ST_DIV_MUL;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_GOTO, ST_CLEAR:
            begin
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_MUL:
            begin
                state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE:
            begin
                if (status.div_done)
                begin
                    state_next = status.negative ? ST_SIGN : ST_DIGIT;
                end
                else
                begin
                    state_next = ST_DIV_MUL;
                end
            end
            ST_SIGN, ST_DIGIT:
            begin
                state_next = ST_CHAR;
            end
            ST_CHAR:
            begin
                // a wrap byte is followed by the character itself
                if (status.emit_done && !status.need_wrap)
                begin
                    state_next = status.char_final ? ST_IDLE : ST_DIGIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.kind       = EMIT_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_GOTO:
            begin
                cmd.emit = 1'b1;
                cmd.kind = EMIT_GOTO;
                cmd.last = 1'b1;
            end
            ST_CLEAR:
            begin
                cmd.emit = 1'b1;
                cmd.kind = EMIT_CLEAR;
                cmd.last = 1'b1;
            end
            ST_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
            end
            ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.pick_sign = 1'b1;
            end
            ST_DIGIT:
            begin
                cmd.pick_digit = 1'b1;
            end
            ST_CHAR:
            begin
                cmd.emit = 1'b1;
                cmd.kind = status.need_wrap ? EMIT_WRAP : EMIT_DATA;
                cmd.last = !status.need_wrap && status.char_final;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/clws_dp.sv
// ---------------------------------------------------------------------------
// clws_dp
// Datapath: cursor, divide-by-ten digit loop, digit store and output register
// ---------------------------------------------------------------------------
`default_nettype none

module clws_dp #(
    parameter int LINE_LENGTH = 16,
    parameter int MAX_DIGITS  = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_valid,
    input  logic                 cfg_interface_mode,
    // request payload
    input  logic [1:0]           req_mode,
    input  logic [7:0]           req_char_code,
    input  logic                 req_row,
    input  logic [5:0]           req_column,
    input  logic signed [31:0]   req_number,
    // controller link
    input  clws_pkg::dp_cmd_t    cmd,
    output clws_pkg::dp_status_t status,
    // display bus
    output logic                 bus_valid,
    input  logic                 bus_ready,
    output logic                 bus_register_select,
    output logic [7:0]           bus_byte,
    output logic                 bus_last
);
    import clws_pkg::*;

    localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // configuration and cursor
    logic               iface4_reg;
    logic               cur_row_reg;
    logic [5:0]         cur_count_reg;

    // request context
    logic               num_reg;
    logic               neg_reg;
    logic [7:0]         char_reg;
    logic               row_req_reg;
    logic [5:0]         col_req_reg;

    // digit conversion
    logic [31:0]        mag_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [NDIG_W-1:0]  ndig_reg;
    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

    // emission
    logic               half_reg;
    logic               out_valid_reg;
    logic               out_rs_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic [31:0]        num_u;
    logic [31:0]        mag_load;
    logic [63:0]        product;
    logic [3:0]         quot_x10_lo;
    logic [DIGIT_W-1:0] rem;
    logic [NDIG_W-1:0]  ndig_dec;
    logic               out_free;
    logic               half_last;
    logic [7:0]         full_byte;
    logic               full_rs;

    // magnitude of the signed request number
    assign num_u    = req_number;
    assign mag_load = num_u[31] ? (~num_u + 32'd1) : num_u;

    // quotient by ten and remainder from the low bits
    assign product     = {32'd0, mag_reg} * {32'd0, RECIP_10};
    assign quot_x10_lo = {quot_reg[0], 3'b000} + {quot_reg[2:0], 1'b0};
    assign rem         = mag_reg[3:0] - quot_x10_lo;
    assign ndig_dec    = ndig_reg - NDIG_W'(1);

    // output register is free when empty or being taken
    assign out_free  = !out_valid_reg || bus_ready;
    assign half_last = !iface4_reg || half_reg;

    // full byte of the current emit
    always_comb
    begin
        full_rs = 1'b0;
        unique case (cmd.kind)
            EMIT_DATA:
            begin
                full_byte = char_reg;
                full_rs   = 1'b1;
            end
            EMIT_GOTO:  full_byte = set_addr_byte(row_req_reg, col_req_reg);
            EMIT_WRAP:  full_byte = set_addr_byte(!cur_row_reg, 6'd0);
            EMIT_CLEAR: full_byte = CMD_CLEAR;
            default:    full_byte = CMD_CLEAR;
        endcase
    end

    // status to controller
    always_comb
    begin
        status.emit_done  = out_free && half_last;
        status.need_wrap  = cur_count_reg >= 6'(LINE_LENGTH);
        status.div_done   = (quot_reg == '0) || (ndig_reg == NDIG_W'(MAX_DIGITS - 1));
        status.negative   = neg_reg;
        status.char_final = !num_reg || (ndig_reg == '0);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iface4_reg    <= 1'b0;
            cur_row_reg   <= 1'b0;
            cur_count_reg <= '0;
            num_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            ndig_reg      <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                iface4_reg <= cfg_interface_mode;
            end

            // request capture
            if (cmd.load)
            begin
                num_reg  <= (req_mode == REQ_NUMBER);
                neg_reg  <= num_u[31];
                ndig_reg <= '0;
                half_reg <= 1'b0;
                if (req_mode == REQ_CLEAR)
                begin
                    cur_row_reg   <= 1'b0;
                    cur_count_reg <= '0;
                end
            end

            if (cmd.div_store)
            begin
                ndig_reg <= ndig_reg + NDIG_W'(1);
            end

            if (cmd.pick_sign)
            begin
                neg_reg <= 1'b0;
            end

            if (cmd.pick_digit)
            begin
                ndig_reg <= ndig_dec;
            end

            // byte emission and cursor update
            if (cmd.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!half_last)
                begin
                    half_reg <= 1'b1;
                end
                else
                begin
                    half_reg <= 1'b0;
                    unique case (cmd.kind)
                        EMIT_DATA:
                        begin
                            cur_count_reg <= cur_count_reg + 6'd1;
                        end
                        EMIT_GOTO:
                        begin
                            cur_row_reg   <= row_req_reg;
                            cur_count_reg <= col_req_reg;
                        end
                        EMIT_WRAP:
                        begin
                            cur_row_reg   <= !cur_row_reg;
                            cur_count_reg <= '0;
                        end
                        EMIT_CLEAR:
                        begin
                            cur_row_reg   <= 1'b0;
                            cur_count_reg <= '0;
                        end
                        default:
                        begin
                            cur_count_reg <= cur_count_reg;
                        end
                    endcase
                end
            end
            else if (bus_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg    <= req_char_code;
            row_req_reg <= req_row;
            col_req_reg <= req_column;
            mag_reg     <= mag_load;
        end
        if (cmd.div_mul)
        begin
            quot_reg <= product[63:RECIP_SHIFT];
        end
        if (cmd.div_store)
        begin
            digit_mem[ndig_reg[DIDX_W-1:0]] <= rem;
            mag_reg                         <= 32'(quot_reg);
        end
        if (cmd.pick_sign)
        begin
            char_reg <= CHAR_MINUS;
        end
        if (cmd.pick_digit)
        begin
            char_reg <= CHAR_ZERO + {4'd0, digit_mem[ndig_dec[DIDX_W-1:0]]};
        end
        if (cmd.emit && out_free)
        begin
            out_rs_reg   <= full_rs;
            out_byte_reg <= half_reg ? ((full_byte & LOW_NIBBLE) << 4) : full_byte;
            out_last_reg <= cmd.last && half_last;
        end
    end

    assign bus_valid           = out_valid_reg;
    assign bus_register_select = out_rs_reg;
    assign bus_byte            = out_byte_reg;
    assign bus_last            = out_last_reg;

endmodule

`default_nettype wire

### rtl/char_lcd_write_sequencer_top.sv
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Turns character display requests into register-select tagged bus bytes.
// One request is in work at a time and bytes leave through an output
// register, at most one per cycle while the bus takes them. A write char
// request gives one byte, or two when the cursor wraps to the other line (a
// set-address command first); goto and clear give one byte each. A write
// number request first runs a divide-by-ten loop with a multiply step and a
// store step per decimal digit, then for each printed character (a minus
// sign first if negative, then the digits) selects it and emits its bytes.
// In four-bit mode every byte goes out as two transfers, the byte and then
// its low nibble in the high half. A bus stall holds the sequence back until
// the bus takes the byte. The next request is taken in the cycle after the
// final transfer reaches the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_write_sequencer_top #(
    parameter int LINE_LENGTH = 16,
    parameter int MAX_DIGITS  = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    clws_req_if.sink          req,
    clws_bus_if.source        bus,
    clws_cfg_if.sink          cfg
);
    import clws_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // register writes are always taken
    assign cfg.ready = 1'b1;

    // controller
    clws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req_kind_t'(req.mode)),
        .req_ready (req.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath
    clws_dp #(
        .LINE_LENGTH (LINE_LENGTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg.valid),
        .cfg_interface_mode  (cfg.interface_mode),
        .req_mode            (req.mode),
        .req_char_code       (req.char_code),
        .req_row             (req.row),
        .req_column          (req.column),
        .req_number          (req.number),
        .cmd                 (cmd),
        .status              (status),
        .bus_valid           (bus.valid),
        .bus_ready           (bus.ready),
        .bus_register_select (bus.register_select),
        .bus_byte            (bus.bus_byte),
        .bus_last            (bus.last)
    );

endmodule

`default_nettype wire

### rtl/clws_checker.sv
// ---------------------------------------------------------------------------
// clws_checker
// Port-level checks of the character LCD write sequencer, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_write_sequencer_top_macros.svh"

module clws_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       bus_valid,
    input logic       bus_ready,
    input logic       bus_register_select,
    input logic [7:0] bus_byte,
    input logic       bus_last
);

    // a stalled bus transfer keeps its payload
    `CLWS_ASSERT_NEXT(a_bus_hold, clk, rst_n, bus_valid && !bus_ready, bus_valid && $stable(bus_byte) && $stable(bus_register_select) && $stable(bus_last), "stalled bus transfer changed")

    // one request at a time: busy right after a request transfer
    `CLWS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while busy")

    // when idle, only the final byte of the previous request may still wait
    `CLWS_ASSERT_SAME(a_idle_only_last, clk, rst_n, req_ready && bus_valid, bus_last, "idle with a non-final byte pending")

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .bus_valid           (bus.valid),
    .bus_ready           (bus.ready),
    .bus_register_select (bus.register_select),
    .bus_byte            (bus.bus_byte),
    .bus_last            (bus.last)
);

`default_nettype wire

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character LCD write sequencer. Requests of all
// four kinds go in through a clocked driver with random gaps, and bus bytes
// are taken by a monitor with random stalls. A shadow of the cursor position
// and the bus mode predicts every bus byte, which is checked field by field
// in order. Directed requests hit the column, wrap and number corner cases,
// then random phases run in both bus modes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import clws_pkg::*;

    localparam int LINE_LENGTH = 16;
    localparam int MAX_DIGITS  = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int DRAIN_CYCLES = 60;

    // one request as the driver puts it on the channel
    typedef struct packed {
        req_kind_t          kind;
        logic [7:0]         char_code;
        logic               row;
        logic [5:0]         column;
        logic signed [31:0] number;
    } lcd_request_t;

    // one bus transfer as the monitor sees it
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } bus_word_t;

    logic clk = 1'b0;
    logic rst_n;

    clws_req_if req_if();
    clws_bus_if bus_if();
    clws_cfg_if cfg_if();

    char_lcd_write_sequencer_top #(
        .LINE_LENGTH (LINE_LENGTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .bus   (bus_if),
        .cfg   (cfg_if)
    );

    // request stimulus and expected bus bytes
    lcd_request_t pending_requests[$];
    bus_word_t    expected_bytes[$];

    // shadow of the cursor and the bus mode
    logic       shadow_row = 1'b0;
    logic [5:0] shadow_col = 6'd0;
    logic       shadow_nibble_mode = 1'b0;

    // handshake bookkeeping
    logic         req_taken = 1'b0;
    logic         bus_taken = 1'b0;
    int           req_gap = 0;
    int           bus_stall = 0;
    bit           req_calm = 1'b0;
    bit           bus_calm = 1'b0;
    int           error_count = 0;
    int           cycle_count = 0;
    lcd_request_t next_req;
    lcd_request_t seen_req;
    bus_word_t    want;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one byte, or byte plus low nibble in four-bit mode
    function automatic void queue_byte(input logic rs, input logic [7:0] value);
        expected_bytes.push_back('{rs, value, 1'b0});
        if (shadow_nibble_mode)
        begin
            expected_bytes.push_back('{rs, {value[3:0], 4'h0}, 1'b0});
        end
    endfunction

    // set-address command, moves the cursor
    function automatic void queue_set_address(input logic r, input logic [5:0] c);
        logic [6:0] addr;
        shadow_row = r;
        shadow_col = c;
        addr = r ? (SECOND_LINE_BASE + {1'b0, c}) : {1'b0, c};
        queue_byte(1'b0, CMD_SET_ADDR | {1'b0, addr});
    endfunction

    // data byte, with a jump to the other line when the line is full
    function automatic void queue_char(input logic [7:0] ch);
        int count_after;
        count_after = int'(shadow_col) + 1;
        if (count_after > LINE_LENGTH)
        begin
            queue_set_address(!shadow_row, 6'd0);
            count_after = 1;
        end
        shadow_col = 6'(count_after);
        queue_byte(1'b1, ch);
    endfunction

    // optional minus sign, then the decimal digits, most significant first
    function automatic void queue_number(input logic signed [31:0] value);
        logic [31:0] magnitude;
        logic [3:0]  digits [MAX_DIGITS];
        int          n;
        magnitude = value;
        n = 0;
        if (value < 0)
        begin
            magnitude = 32'd0 - $unsigned(value);
            queue_char(CHAR_MINUS);
        end
        do
        begin
            digits[n] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            n++;
        end
        while (magnitude != 0 && n < MAX_DIGITS);
        while (n > 0)
        begin
            n--;
            queue_char(CHAR_ZERO + {4'h0, digits[n]});
        end
    endfunction

    // all bus bytes of one accepted request, the final one tagged last
    function automatic void predict_bus_bytes(input lcd_request_t r);
        case (r.kind)
            REQ_CHAR:  queue_char(r.char_code);
            REQ_GOTO:  queue_set_address(r.row, r.column);
            REQ_CLEAR:
            begin
                shadow_row = 1'b0;
                shadow_col = 6'd0;
                queue_byte(1'b0, CMD_CLEAR);
            end
            default:   queue_number(r.number);
        endcase
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers, unused fields get random values
    // ------------------------------------------------------------------

    function automatic lcd_request_t random_fields(input req_kind_t kind);
        lcd_request_t r;
        r.kind      = kind;
        r.char_code = 8'($urandom);
        r.row       = 1'($urandom);
        r.column    = 6'($urandom);
        r.number    = $urandom;
        return r;
    endfunction

    task automatic enqueue_char(input logic [7:0] ch);
        lcd_request_t r;
        r = random_fields(REQ_CHAR);
        r.char_code = ch;
        pending_requests.push_back(r);
    endtask

    task automatic enqueue_goto(input logic r_row, input logic [5:0] col);
        lcd_request_t r;
        r = random_fields(REQ_GOTO);
        r.row = r_row;
        r.column = col;
        pending_requests.push_back(r);
    endtask

    task automatic enqueue_clear();
        pending_requests.push_back(random_fields(REQ_CLEAR));
    endtask

    task automatic enqueue_number(input logic signed [31:0] value);
        lcd_request_t r;
        r = random_fields(REQ_NUMBER);
        r.number = value;
        pending_requests.push_back(r);
    endtask

    // mostly characters so lines fill and wrap, gotos mostly on screen
    task automatic enqueue_random_request();
        int                 pick;
        int                 shape;
        logic signed [31:0] value;
        pick = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        if (pick < 45)
        begin
            enqueue_char(8'($urandom));
        end
        else if (pick < 63)
        begin
            enqueue_goto(1'($urandom), ($urandom_range(0, 5) == 0) ?
                         6'($urandom) : 6'($urandom_range(0, LINE_LENGTH - 1)));
        end
        else if (pick < 70)
        begin
            enqueue_clear();
        end
        else
        begin
            if (shape < 2)
                value = $urandom_range(0, 99);
            else if (shape < 3)
                value = -int'($urandom_range(1, 99999));
            else if (shape < 5)
                value = $urandom;
            else if (shape < 9)
                value = $signed($urandom) >>> $urandom_range(0, 31);
            else
                value = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            enqueue_number(value);
        end
    endtask

    // one register transfer on the configuration channel
    task automatic write_interface_mode(input logic four_bit);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.interface_mode <= four_bit;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        shadow_nibble_mode = four_bit;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // block is idle once every request is in and every byte is out
    task automatic wait_idle();
        while (pending_requests.size() != 0 || req_if.valid || expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(req_if.valid && !req_taken))
        begin
            if (req_gap > 0)
            begin
                req_if.valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                req_if.valid     <= 1'b1;
                req_if.mode      <= next_req.kind;
                req_if.char_code <= next_req.char_code;
                req_if.row       <= next_req.row;
                req_if.column    <= next_req.column;
                req_if.number    <= next_req.number;
                if ($urandom_range(0, 15) == 0)
                    req_calm = !req_calm;
                req_gap <= req_calm ? 0 : $urandom_range(0, 19);
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // bus ready, held low for a random stall after each transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bus_taken)
            begin
                if ($urandom_range(0, 23) == 0)
                    bus_calm = !bus_calm;
                bus_stall = bus_calm ? 0 : $urandom_range(0, 19);
            end
            if (bus_stall > 0)
            begin
                bus_if.ready <= 1'b0;
                bus_stall = bus_stall - 1;
            end
            else
            begin
                bus_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on request transfers, check bus transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_if.valid && req_if.ready;
            bus_taken <= bus_if.valid && bus_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                seen_req = '{req_kind_t'(req_if.mode), req_if.char_code, req_if.row,
                             req_if.column, req_if.number};
                predict_bus_bytes(seen_req);
            end
            if (bus_if.valid && bus_if.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected transfer: register_select %0d bus_byte 0x%02h last %0d",
                           bus_if.register_select, bus_if.bus_byte, bus_if.last);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (bus_if.register_select !== want.rs)
                    begin
                        $error("register_select: expected %0d, actual %0d",
                               want.rs, bus_if.register_select);
                        error_count++;
                    end
                    if (bus_if.bus_byte !== want.data)
                    begin
                        $error("bus_byte: expected 0x%02h, actual 0x%02h",
                               want.data, bus_if.bus_byte);
                        error_count++;
                    end
                    if (bus_if.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, bus_if.last);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode = REQ_CHAR;
        req_if.char_code = 8'h00;
        req_if.row = 1'b0;
        req_if.column = 6'd0;
        req_if.number = 32'sd0;
        bus_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.interface_mode = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed part on the eight-bit bus
        write_interface_mode(1'b0);
        enqueue_clear();
        enqueue_char(8'h00);
        enqueue_char(8'hFF);
        enqueue_goto(1'b0, 6'd0);
        enqueue_goto(1'b1, 6'd63);
        // column past the line end wraps on the next character
        enqueue_char(8'h41);
        enqueue_goto(1'b0, 6'd15);
        enqueue_char(8'h5A);
        enqueue_char(8'h61);
        enqueue_goto(1'b1, 6'd39);
        // zero, negatives, both extremes
        enqueue_number(32'sd0);
        enqueue_number(-32'sd1);
        enqueue_number(32'sh7FFF_FFFF);
        enqueue_number(32'sh8000_0000);
        enqueue_number(32'sd10);
        enqueue_number(-32'sd906);
        // number that wraps midway
        enqueue_goto(1'b0, 6'd10);
        enqueue_number(32'sd1234567);
        enqueue_clear();
        enqueue_goto(1'b1, 6'd16);
        enqueue_char(8'h7E);
        enqueue_goto(1'b0, 6'd42);

        // random phases, bus mode alternating
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_interface_mode(phase % 2 == 0);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                enqueue_random_request();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/clws_pkg.sv
rtl/clws_if.sv
rtl/clws_ctrl.sv
rtl/clws_dp.sv
rtl/char_lcd_write_sequencer_top.sv
rtl/clws_checker.sv
dv/tb_top.sv
